### design/ring_neighbor_arbiter_aging_macros.svh
// assertion macros shared by the arbiter modules
`ifndef RING_NEIGHBOR_ARBITER_AGING_MACROS_SVH
`define RING_NEIGHBOR_ARBITER_AGING_MACROS_SVH

// same-cycle implication, checked outside reset
`define RNAA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("arbiter check failed");

// next-cycle implication, checked outside reset
`define RNAA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("arbiter check failed");

`endif

### design/rnaa_pkg.sv
package rnaa_pkg;

    // default sizing
    localparam int MAX_REQUESTERS_DEF = 8;
    localparam int TIME_BITS_DEF      = 32;

    // field widths
    localparam int REQ_TYPE_W   = 2;
    localparam int REQ_ID_W     = 3;
    localparam int GRANT_ID_W   = 3;
    localparam int RING_SIZE_W  = 4;
    localparam int AGE_LIMIT_W  = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 8;

    // register reset values
    localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 4'd5;
    localparam logic [AGE_LIMIT_W-1:0] AGE_LIMIT_RESET = 16'd25;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RING_SIZE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AGE_LIMIT = 1'd1;

    // item kinds
    localparam logic [REQ_TYPE_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_ACQUIRE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd2;

    // requester phases as stored in the state memory
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_WAIT  = 2'd1;
    localparam logic [1:0] PH_GRANT = 2'd2;

    // one grant result
    typedef struct packed {
        logic [GRANT_ID_W-1:0] grant_id;
        logic                  last;
    } res_t;

endpackage

### design/ring_neighbor_arbiter_aging.sv
// Ring arbiter with aging: each item is a tick, a request or a release from one requester,
// and every grant it causes comes out as one result item (grant_id, tlast on the final one).
// A tick finishes in its accept cycle. A request or release goes through the accept state,
// the read states that address five entries of the state memory (the requester, its two
// neighbors and theirs) over two read ports, a state for the last read data, since the
// memory reads are registered, and the check. A release from a granted requester then goes
// on, whether or not it grants, to the right re-check and a state for each possible grant,
// since the single write port writes one entry per cycle. Whenever a grant is ready and the
// two-entry result queue is full, the sequencer waits until the queue has room. Items whose
// requester lies outside the ring, or whose kind is not used, finish in their accept cycle.
// The state memory needs no clearing pass after reset.
// Configuration writes are always ready and are meant for idle times only.
module ring_neighbor_arbiter_aging #(
    parameter int MAX_REQUESTERS = rnaa_pkg::MAX_REQUESTERS_DEF,
    parameter int TIME_BITS      = rnaa_pkg::TIME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rnaa_pkg::S_TDATA_W-1:0]     s_tdata,   // req_type[1:0], requester_id[4:2]
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rnaa_pkg::M_TDATA_W-1:0]     m_tdata,   // grant_id[2:0]
    output logic                               m_tlast,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rnaa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rnaa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(MAX_REQUESTERS);
    localparam int DW    = TIME_BITS + 2;

    logic [rnaa_pkg::RING_SIZE_W-1:0] ring_size_reg;
    logic [rnaa_pkg::AGE_LIMIT_W-1:0] age_limit_reg;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [DW-1:0]    mem_wr_data;
    logic [IDX_W-1:0] mem_rd0_addr;
    logic [IDX_W-1:0] mem_rd1_addr;
    logic [DW-1:0]    mem_rd0_data;
    logic [DW-1:0]    mem_rd1_data;

    logic             res_push;
    logic             res_full;
    rnaa_pkg::res_t   res_in;
    rnaa_pkg::res_t   res_out;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_size_reg <= rnaa_pkg::RING_SIZE_RESET;
            age_limit_reg <= rnaa_pkg::AGE_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rnaa_pkg::CFG_RING_SIZE: ring_size_reg <= cfg_data[rnaa_pkg::RING_SIZE_W-1:0];
                rnaa_pkg::CFG_AGE_LIMIT: age_limit_reg <= cfg_data[rnaa_pkg::AGE_LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    rnaa_ctrl #(
        .MAX_REQUESTERS (MAX_REQUESTERS),
        .TIME_BITS      (TIME_BITS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_req_type     (s_tdata[1:0]),
        .in_requester_id (s_tdata[4:2]),
        .ring_size       (ring_size_reg),
        .age_limit       (age_limit_reg),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .mem_rd0_addr    (mem_rd0_addr),
        .mem_rd1_addr    (mem_rd1_addr),
        .mem_rd0_data    (mem_rd0_data),
        .mem_rd1_data    (mem_rd1_data),
        .res_push        (res_push),
        .res_data        (res_in),
        .res_full        (res_full)
    );

    // phase and stamp store
    rnaa_state_mem #(
        .DEPTH     (MAX_REQUESTERS),
        .TIME_BITS (TIME_BITS)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .rd0_addr (mem_rd0_addr),
        .rd1_addr (mem_rd1_addr),
        .rd0_data (mem_rd0_data),
        .rd1_data (mem_rd1_data)
    );

    // result queue
    rnaa_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (res_out)
    );

    assign m_tdata = {{(rnaa_pkg::M_TDATA_W - rnaa_pkg::GRANT_ID_W){1'b0}}, res_out.grant_id};
    assign m_tlast = res_out.last;

endmodule

### design/rnaa_state_mem.sv
module rnaa_state_mem #(
    parameter int DEPTH     = rnaa_pkg::MAX_REQUESTERS_DEF,
    parameter int TIME_BITS = rnaa_pkg::TIME_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [TIME_BITS+1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0]    rd0_addr,
    input  logic [$clog2(DEPTH)-1:0]    rd1_addr,
    output logic [TIME_BITS+1:0]        rd0_data,
    output logic [TIME_BITS+1:0]        rd1_data
);

    localparam int DW = TIME_BITS + 2;
    localparam logic [DW-1:0] IDLE_ENT = {rnaa_pkg::PH_IDLE, {TIME_BITS{1'b0}}};

    logic [DW-1:0]    mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    rd0_q_reg;
    logic [DW-1:0]    rd1_q_reg;
    logic             rd0_vld_reg;
    logic             rd1_vld_reg;

    // entry storage, one write and two registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd0_q_reg <= mem_reg[rd0_addr];
        rd1_q_reg <= mem_reg[rd1_addr];
    end

    // per-entry valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            rd0_vld_reg <= 1'b0;
            rd1_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd0_vld_reg <= valid_reg[rd0_addr];
            rd1_vld_reg <= valid_reg[rd1_addr];
        end
    end

    // never-written entries read as idle
    assign rd0_data = rd0_vld_reg ? rd0_q_reg : IDLE_ENT;
    assign rd1_data = rd1_vld_reg ? rd1_q_reg : IDLE_ENT;

endmodule

### design/rnaa_out_fifo.sv
`include "ring_neighbor_arbiter_aging_macros.svh"

module rnaa_out_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rnaa_pkg::res_t push_data,
    output logic          full,
    output logic          m_valid,
    input  logic          m_ready,
    output rnaa_pkg::res_t m_data
);

    rnaa_pkg::res_t slot_reg [2];
    logic [1:0]     count_reg;
    logic           pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == 2'd2);
    assign m_data  = slot_reg[0];

    // two-slot queue, head always in slot 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // slot data
    always_ff @(posedge aclk) begin
        if (pop && push) begin
            slot_reg[0] <= push_data;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
        end else if (push) begin
            slot_reg[count_reg[0]] <= push_data;
        end
    end

    `RNAA_ASSERT_IMPL(a_fifo_no_overflow, aclk, aresetn, push, count_reg != 2'd2)
    `RNAA_ASSERT_IMPL(a_fifo_count_range, aclk, aresetn, 1'b1, count_reg != 2'd3)

endmodule

### design/rnaa_ctrl.sv
`include "ring_neighbor_arbiter_aging_macros.svh"

module rnaa_ctrl #(
    parameter int MAX_REQUESTERS = rnaa_pkg::MAX_REQUESTERS_DEF,
    parameter int TIME_BITS      = rnaa_pkg::TIME_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rnaa_pkg::REQ_TYPE_W-1:0]      in_req_type,
    input  logic [rnaa_pkg::REQ_ID_W-1:0]        in_requester_id,
    input  logic [rnaa_pkg::RING_SIZE_W-1:0]     ring_size,
    input  logic [rnaa_pkg::AGE_LIMIT_W-1:0]     age_limit,
    output logic                                 mem_wr_en,
    output logic [$clog2(MAX_REQUESTERS)-1:0]    mem_wr_addr,
    output logic [TIME_BITS+1:0]                 mem_wr_data,
    output logic [$clog2(MAX_REQUESTERS)-1:0]    mem_rd0_addr,
    output logic [$clog2(MAX_REQUESTERS)-1:0]    mem_rd1_addr,
    input  logic [TIME_BITS+1:0]                 mem_rd0_data,
    input  logic [TIME_BITS+1:0]                 mem_rd1_data,
    output logic                                 res_push,
    output rnaa_pkg::res_t                       res_data,
    input  logic                                 res_full
);

    localparam int IDX_W  = $clog2(MAX_REQUESTERS);
    localparam int SIZE_W = $clog2(MAX_REQUESTERS + 1);
    localparam int CW     = (SIZE_W > rnaa_pkg::RING_SIZE_W) ? SIZE_W : rnaa_pkg::RING_SIZE_W;
    localparam int DW     = TIME_BITS + 2;
    localparam int AGE_W  = (TIME_BITS > rnaa_pkg::AGE_LIMIT_W) ? TIME_BITS
                                                                : rnaa_pkg::AGE_LIMIT_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [DW-1:0] IDLE_ENT = {rnaa_pkg::PH_IDLE, {TIME_BITS{1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RD4,
        ST_EVAL,
        ST_EVAL_R,
        ST_PUSH_L,
        ST_PUSH_R
    } state_t;

    state_t               state_reg, state_next;
    logic                 is_rel_reg, is_rel_next;
    logic [IDX_W-1:0]     s_reg, s_next;
    logic [IDX_W-1:0]     l_reg, l_next;
    logic [IDX_W-1:0]     r_reg, r_next;
    logic [IDX_W-1:0]     ll_reg, ll_next;
    logic [IDX_W-1:0]     rr_reg, rr_next;
    logic [DW-1:0]        ent_s_reg, ent_s_next;
    logic [DW-1:0]        ent_l_reg, ent_l_next;
    logic [DW-1:0]        ent_r_reg, ent_r_next;
    logic [DW-1:0]        ent_ll_reg, ent_ll_next;
    logic [DW-1:0]        ent_rr_reg, ent_rr_next;
    logic                 gl_reg, gl_next;
    logic                 gr_reg, gr_next;
    logic [TIME_BITS-1:0] now_reg, now_next;

    logic [CW-1:0]        rs_ext;
    logic [SIZE_W-1:0]    size_eff;
    logic [IDX_W-1:0]     id_idx;
    logic [IDX_W-1:0]     id_l;
    logic [IDX_W-1:0]     id_r;
    logic [DW-1:0]        ll_eff;
    logic [DW-1:0]        r_eff;
    logic [DW-1:0]        rr_eff;
    logic [DW-1:0]        l_granted;
    logic                 req_grant;

    // entry field access
    function automatic logic [1:0] ent_ph(input logic [DW-1:0] e);
        ent_ph = e[DW-1 -: 2];
    endfunction

    function automatic logic [TIME_BITS-1:0] ent_st(input logic [DW-1:0] e);
        ent_st = e[TIME_BITS-1:0];
    endfunction

    // ring neighbors
    function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i,
                                                   input logic [SIZE_W-1:0] n);
        ring_prev = (i == '0) ? IDX_W'(n - SIZE_W'(1)) : i - IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                   input logic [SIZE_W-1:0] n);
        ring_next = (SIZE_W'(SIZE_W'(i) + SIZE_W'(1)) == n) ? '0 : i + IDX_W'(1);
    endfunction

    // neighbor does not block: not granted, and not waiting long from an earlier stamp
    function automatic logic nb_ok(input logic [DW-1:0] nb,
                                   input logic [TIME_BITS-1:0] self_st,
                                   input logic [TIME_BITS-1:0] t,
                                   input logic [rnaa_pkg::AGE_LIMIT_W-1:0] lim);
        logic [1:0]           ph;
        logic [TIME_BITS-1:0] st;
        logic [TIME_BITS-1:0] age;
        logic                 aged;
        ph    = ent_ph(nb);
        st    = ent_st(nb);
        age   = t - st;
        aged  = (ph == rnaa_pkg::PH_WAIT) && (st < self_st) && (AGE_W'(age) >= AGE_W'(lim));
        nb_ok = (ph != rnaa_pkg::PH_GRANT) && !aged;
    endfunction

    // effective ring size, clamped
    always_comb begin
        rs_ext = CW'(ring_size);
        if (rs_ext < CW'(2)) begin
            size_eff = SIZE_W'(2);
        end else if (rs_ext > CW'(MAX_REQUESTERS)) begin
            size_eff = SIZE_W'(MAX_REQUESTERS);
        end else begin
            size_eff = SIZE_W'(rs_ext);
        end
    end

    assign id_idx = IDX_W'(in_requester_id);
    assign id_l   = ring_prev(id_idx, size_eff);
    assign id_r   = ring_next(id_idx, size_eff);

    // forwarded views for the release re-checks
    assign l_granted = {rnaa_pkg::PH_GRANT, ent_st(ent_l_reg)};
    assign ll_eff    = (ll_reg == s_reg) ? IDLE_ENT : ent_ll_reg;
    assign r_eff     = ((r_reg == l_reg) && gl_reg) ? l_granted : ent_r_reg;
    assign rr_eff    = (rr_reg == s_reg) ? IDLE_ENT :
                       ((rr_reg == l_reg) && gl_reg) ? l_granted : ent_rr_reg;

    // request check against both neighbors, own stamp is now
    assign req_grant = nb_ok(ent_l_reg, now_reg, now_reg, age_limit) &&
                       nb_ok(ent_r_reg, now_reg, now_reg, age_limit);

    assign in_ready = (state_reg == ST_IDLE);

    // read address sequence
    always_comb begin
        case (state_reg)
            ST_RD1: begin
                mem_rd0_addr = s_reg;
                mem_rd1_addr = l_reg;
            end
            ST_RD2: begin
                mem_rd0_addr = r_reg;
                mem_rd1_addr = ll_reg;
            end
            ST_RD3: begin
                mem_rd0_addr = rr_reg;
                mem_rd1_addr = rr_reg;
            end
            default: begin
                mem_rd0_addr = s_reg;
                mem_rd1_addr = l_reg;
            end
        endcase
    end

    // sequencer next state, writes and result pushes
    always_comb begin
        state_next  = state_reg;
        is_rel_next = is_rel_reg;
        s_next      = s_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        ll_next     = ll_reg;
        rr_next     = rr_reg;
        ent_s_next  = ent_s_reg;
        ent_l_next  = ent_l_reg;
        ent_r_next  = ent_r_reg;
        ent_ll_next = ent_ll_reg;
        ent_rr_next = ent_rr_reg;
        gl_next     = gl_reg;
        gr_next     = gr_reg;
        now_next    = now_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = s_reg;
        mem_wr_data = IDLE_ENT;
        res_push    = 1'b0;
        res_data.grant_id = rnaa_pkg::GRANT_ID_W'(s_reg);
        res_data.last     = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_req_type)
                        rnaa_pkg::REQ_TICK: begin
                            if (now_reg != TIME_MAX) begin
                                now_next = now_reg + TIME_BITS'(1);
                            end
                        end
                        rnaa_pkg::REQ_ACQUIRE, rnaa_pkg::REQ_RELEASE: begin
                            if (CW'(in_requester_id) < CW'(size_eff)) begin
                                is_rel_next = (in_req_type == rnaa_pkg::REQ_RELEASE);
                                s_next      = id_idx;
                                l_next      = id_l;
                                r_next      = id_r;
                                ll_next     = ring_prev(id_l, size_eff);
                                rr_next     = ring_next(id_r, size_eff);
                                state_next  = ST_RD1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD1: begin
                state_next = ST_RD2;
            end
            ST_RD2: begin
                ent_s_next = mem_rd0_data;
                ent_l_next = mem_rd1_data;
                state_next = ST_RD3;
            end
            ST_RD3: begin
                ent_r_next  = mem_rd0_data;
                ent_ll_next = mem_rd1_data;
                state_next  = ST_RD4;
            end
            ST_RD4: begin
                ent_rr_next = mem_rd0_data;
                state_next  = ST_EVAL;
            end
            ST_EVAL: begin
                if (!is_rel_reg) begin
                    // request: only from idle, stamp and grant if allowed
                    if (ent_ph(ent_s_reg) != rnaa_pkg::PH_IDLE) begin
                        state_next = ST_IDLE;
                    end else if (!(req_grant && res_full)) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = s_reg;
                        mem_wr_data = {req_grant ? rnaa_pkg::PH_GRANT : rnaa_pkg::PH_WAIT,
                                       now_reg};
                        res_push    = req_grant;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    // release: only from granted, then re-check left
                    if (ent_ph(ent_s_reg) != rnaa_pkg::PH_GRANT) begin
                        state_next = ST_IDLE;
                    end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = s_reg;
                        mem_wr_data = {rnaa_pkg::PH_IDLE, ent_st(ent_s_reg)};
                        gl_next     = (ent_ph(ent_l_reg) == rnaa_pkg::PH_WAIT) &&
                                      nb_ok(ll_eff, ent_st(ent_l_reg), now_reg, age_limit);
                        state_next  = ST_EVAL_R;
                    end
                end
            end
            ST_EVAL_R: begin
                // right re-check sees the left grant
                gr_next    = (ent_ph(r_eff) == rnaa_pkg::PH_WAIT) &&
                             nb_ok(rr_eff, ent_st(r_eff), now_reg, age_limit);
                state_next = ST_PUSH_L;
            end
            ST_PUSH_L: begin
                if (!gl_reg) begin
                    state_next = ST_PUSH_R;
                end else if (!res_full) begin
                    mem_wr_en         = 1'b1;
                    mem_wr_addr       = l_reg;
                    mem_wr_data       = l_granted;
                    res_push          = 1'b1;
                    res_data.grant_id = rnaa_pkg::GRANT_ID_W'(l_reg);
                    res_data.last     = !gr_reg;
                    state_next        = ST_PUSH_R;
                end
            end
            ST_PUSH_R: begin
                if (!gr_reg) begin
                    state_next = ST_IDLE;
                end else if (!res_full) begin
                    mem_wr_en         = 1'b1;
                    mem_wr_addr       = r_reg;
                    mem_wr_data       = {rnaa_pkg::PH_GRANT, ent_st(ent_r_reg)};
                    res_push          = 1'b1;
                    res_data.grant_id = rnaa_pkg::GRANT_ID_W'(r_reg);
                    res_data.last     = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered context
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            now_reg   <= '0;
            gl_reg    <= 1'b0;
            gr_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            now_reg    <= now_next;
            gl_reg     <= gl_next;
            gr_reg     <= gr_next;
            is_rel_reg <= is_rel_next;
            s_reg      <= s_next;
            l_reg      <= l_next;
            r_reg      <= r_next;
            ll_reg     <= ll_next;
            rr_reg     <= rr_next;
            ent_s_reg  <= ent_s_next;
            ent_l_reg  <= ent_l_next;
            ent_r_reg  <= ent_r_next;
            ent_ll_reg <= ent_ll_next;
            ent_rr_reg <= ent_rr_next;
        end
    end

    `RNAA_ASSERT_IMPL(a_no_write_when_idle, aclk, aresetn, mem_wr_en, state_reg != ST_IDLE)
    `RNAA_ASSERT_IMPL(a_push_has_room, aclk, aresetn, res_push, !res_full)
    `RNAA_ASSERT_IMPL(a_now_monotonic, aclk, aresetn, $past(aresetn), now_reg >= $past(now_reg))
    `RNAA_ASSERT_IMPL(a_two_grants_differ, aclk, aresetn, (state_reg == ST_PUSH_R) && gl_reg && gr_reg, r_reg != l_reg)

endmodule
